/* design/line_rasterizer_dda_macros.svh */
// Assertion macros shared by the line rasterizer checks.
`ifndef LINE_RASTERIZER_DDA_MACROS_SVH
`define LINE_RASTERIZER_DDA_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LRD_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LRD_IMPLY_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lrd_pkg.sv */
// Shared types and constants for the line rasterizer.
`timescale 1ns / 1ps

package lrd_pkg;

   localparam int COORD_BITS  = 16;
   localparam int COLOR_BITS  = 32;
   localparam int QUEUE_DEPTH = 2;
   // signed endpoint difference
   localparam int DELTA_BITS  = COORD_BITS + 1;
   // rounding remainder spans [-2n, 4n) before correction
   localparam int REM_BITS    = COORD_BITS + 3;

   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } lrd_op_type;

   typedef struct packed {
      lrd_op_type                    operation;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
      logic                          fill_corners;
   } lrd_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      logic [COLOR_BITS-1:0]         pixel_color;
      logic                          line_done;
   } lrd_rsp_type;

   // Classified command held in the queue between front and back
   typedef struct packed {
      lrd_op_type                    op;
      logic                          major_is_x;
      logic                          major_dir;
      logic                          corner_mode;
      logic [COORD_BITS-1:0]         steps;
      logic [COORD_BITS-1:0]         major_start;
      logic [COORD_BITS-1:0]         minor_start;
      logic signed [DELTA_BITS-1:0]  delta;
   } lrd_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lrd_queue_status_type;

   typedef struct packed {
      logic active;
      logic corner_pend;
      logic pop;
   } lrd_back_status_type;

endpackage

/* design/lrd_front.sv */
// Front end: classify an incoming item and set up the line parameters.
`timescale 1ns / 1ps

module lrd_front (
   input  lrd_pkg::lrd_req_type req_data,
   output lrd_pkg::lrd_cmd_type cmd
);

   logic signed [lrd_pkg::COORD_BITS-1:0] x1, y1, x2, y2;
   logic signed [lrd_pkg::DELTA_BITS-1:0] dx, dy;
   logic [lrd_pkg::DELTA_BITS-1:0]        adx_w, ady_w;
   logic [lrd_pkg::COORD_BITS-1:0]        adx, ady;
   logic                                  x_major;

   assign x1 = req_data.start_x;
   assign y1 = req_data.start_y;
   assign x2 = req_data.end_x;
   assign y2 = req_data.end_y;

   // Differences and magnitudes; magnitudes fit in the coordinate width
   assign dx    = lrd_pkg::DELTA_BITS'(x2) - lrd_pkg::DELTA_BITS'(x1);
   assign dy    = lrd_pkg::DELTA_BITS'(y2) - lrd_pkg::DELTA_BITS'(y1);
   assign adx_w = dx[lrd_pkg::DELTA_BITS-1] ? -dx : dx;
   assign ady_w = dy[lrd_pkg::DELTA_BITS-1] ? -dy : dy;
   assign adx   = adx_w[lrd_pkg::COORD_BITS-1:0];
   assign ady   = ady_w[lrd_pkg::COORD_BITS-1:0];

   // Ties go to the y axis
   assign x_major = adx > ady;

   // Pick major and minor axes
   always_comb begin
      cmd.op          = req_data.operation;
      cmd.major_is_x  = x_major;
      cmd.corner_mode = req_data.fill_corners;
      if (x_major) begin
         cmd.steps       = adx;
         cmd.major_start = x1;
         cmd.minor_start = y1;
         cmd.major_dir   = dx[lrd_pkg::DELTA_BITS-1];
         cmd.delta       = dy;
      end else begin
         cmd.steps       = ady;
         cmd.major_start = y1;
         cmd.minor_start = x1;
         cmd.major_dir   = dy[lrd_pkg::DELTA_BITS-1];
         cmd.delta       = dx;
      end
   end

endmodule

/* design/lrd_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module lrd_queue #(
   parameter int DEPTH = lrd_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lrd_pkg::lrd_cmd_type          push_data,
   input  logic                          pop,
   output lrd_pkg::lrd_cmd_type          head,
   output lrd_pkg::lrd_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lrd_pkg::lrd_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* design/lrd_back.sv */
// Back end: step the line and drive pixels through the output register.
`timescale 1ns / 1ps

module lrd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lrd_pkg::COLOR_BITS-1:0] color,
   input  lrd_pkg::lrd_cmd_type           head,
   input  logic                           q_empty,
   output lrd_pkg::lrd_back_status_type   status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lrd_pkg::lrd_rsp_type           rsp_data
);

   localparam int CB = lrd_pkg::COORD_BITS;
   localparam int RB = lrd_pkg::REM_BITS;

   // control
   logic active_ff, active_in;
   logic pend_ff, pend_in;
   logic out_valid_ff, out_valid_in;
   // line state
   logic [CB-1:0]                        steps_left_ff, steps_left_in;
   logic [CB:0]                          two_n_ff, two_n_in;
   logic [CB-1:0]                        major_ff, major_in;
   logic [CB-1:0]                        minor_ff, minor_in;
   logic [CB-1:0]                        prev_ff, prev_in;
   logic                                 dir_ff, dir_in;
   logic                                 x_major_ff, x_major_in;
   logic                                 corner_mode_ff, corner_mode_in;
   logic signed [lrd_pkg::DELTA_BITS-1:0] delta_ff, delta_in;
   logic signed [RB-1:0]                 rem_ff, rem_in;
   // pending corner pixel and output register
   logic [CB-1:0]                        pend_x_ff, pend_x_in;
   logic [CB-1:0]                        pend_y_ff, pend_y_in;
   logic                                 pend_done_ff, pend_done_in;
   lrd_pkg::lrd_rsp_type                 out_ff, out_in;

   logic                 out_free, emits, pop, last, corner;
   logic signed [RB-1:0] delta_ext, two_d, two_n_ext, sum, sum_lo, sum_hi;

   // Map major/minor back to x/y
   function automatic lrd_pkg::lrd_rsp_type make_pixel(
      input logic                           xm,
      input logic [CB-1:0]                  maj,
      input logic [CB-1:0]                  mnr,
      input logic [lrd_pkg::COLOR_BITS-1:0] col,
      input logic                           done
   );
      lrd_pkg::lrd_rsp_type p;
      p.pixel_x     = xm ? maj : mnr;
      p.pixel_y     = xm ? mnr : maj;
      p.pixel_color = col;
      p.line_done   = done;
      return p;
   endfunction

   // Remainder update: three sums in parallel, pick by sign
   assign delta_ext = RB'(delta_ff);
   assign two_d     = delta_ext <<< 1;
   assign two_n_ext = RB'(two_n_ff);
   assign sum       = rem_ff + two_d;
   assign sum_lo    = rem_ff + two_d - two_n_ext;
   assign sum_hi    = rem_ff + two_d + two_n_ext;

   assign out_free = !out_valid_ff || rsp_ready;
   assign emits    = (head.op == lrd_pkg::OP_ADVANCE) && active_ff;
   assign pop      = !q_empty && !pend_ff && (out_free || !emits);
   assign last     = (steps_left_ff == '0);
   assign corner   = corner_mode_ff && (minor_ff != prev_ff);

   // Next state: drain a pending corner first, else take the head item
   always_comb begin
      active_in      = active_ff;
      pend_in        = pend_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      steps_left_in  = steps_left_ff;
      two_n_in       = two_n_ff;
      major_in       = major_ff;
      minor_in       = minor_ff;
      prev_in        = prev_ff;
      dir_in         = dir_ff;
      x_major_in     = x_major_ff;
      corner_mode_in = corner_mode_ff;
      delta_in       = delta_ff;
      rem_in         = rem_ff;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      pend_done_in   = pend_done_ff;
      out_in         = out_ff;

      if (out_free && pend_ff) begin
         out_valid_in = 1'b1;
         out_in       = make_pixel(1'b1, pend_x_ff, pend_y_ff, color, pend_done_ff);
         pend_in      = 1'b0;
      end

      if (pop) begin
         unique case (head.op)
            lrd_pkg::OP_START: begin
               active_in      = 1'b1;
               steps_left_in  = head.steps;
               two_n_in       = {head.steps, 1'b0};
               major_in       = head.major_start;
               minor_in       = head.minor_start;
               prev_in        = head.minor_start;
               dir_in         = head.major_dir;
               x_major_in     = head.major_is_x;
               corner_mode_in = head.corner_mode;
               delta_in       = head.delta;
               rem_in         = RB'(head.steps);
            end
            lrd_pkg::OP_ADVANCE: begin
               if (active_ff) begin
                  // main pixel, then maybe the corner at the old minor value
                  out_valid_in = 1'b1;
                  out_in = make_pixel(x_major_ff, major_ff, minor_ff, color,
                                      last && !corner);
                  if (corner) begin
                     pend_in      = 1'b1;
                     pend_x_in    = x_major_ff ? major_ff : prev_ff;
                     pend_y_in    = x_major_ff ? prev_ff : major_ff;
                     pend_done_in = last;
                  end
                  if (last) begin
                     active_in = 1'b0;
                  end else begin
                     prev_in       = minor_ff;
                     steps_left_in = steps_left_ff - CB'(1);
                     major_in      = dir_ff ? major_ff - CB'(1) : major_ff + CB'(1);
                     priority if (!sum_lo[RB-1]) begin
                        rem_in   = sum_lo;
                        minor_in = minor_ff + CB'(1);
                     end else if (sum[RB-1]) begin
                        rem_in   = sum_hi;
                        minor_in = minor_ff - CB'(1);
                     end else begin
                        rem_in   = sum;
                     end
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Line state and payload registers
   always_ff @(posedge clock) begin
      steps_left_ff  <= steps_left_in;
      two_n_ff       <= two_n_in;
      major_ff       <= major_in;
      minor_ff       <= minor_in;
      prev_ff        <= prev_in;
      dir_ff         <= dir_in;
      x_major_ff     <= x_major_in;
      corner_mode_ff <= corner_mode_in;
      delta_ff       <= delta_in;
      rem_ff         <= rem_in;
      pend_x_ff      <= pend_x_in;
      pend_y_ff      <= pend_y_in;
      pend_done_ff   <= pend_done_in;
      out_ff         <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data           = out_ff;
   assign status.active      = active_ff;
   assign status.corner_pend = pend_ff;
   assign status.pop         = pop;

endmodule

/* design/line_rasterizer_dda.sv */
// Top level of the DDA line pixel generator.
`timescale 1ns / 1ps
`include "line_rasterizer_dda_macros.svh"

//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------------
//  req     | req_valid req_ready req_data   | start (endpoints, corner fill) / advance
//  rsp     | rsp_valid rsp_ready rsp_data   | pixel x, y, color, last-pixel flag
//  csr     | csr_write_en csr_write_data    | draw color, registered
//
//  One item per clock when the result side keeps up; an advance that adds a corner
//  pixel holds the back end until its second result moves to the output register.
//  A pixel enters the output register as its item leaves the command queue head.
//  Start items and idle advances drain during an output stall unless a corner pends.
//  Synchronous reset empties the queue, ends the line, drops output valid, clears color.

module line_rasterizer_dda #(
   parameter int QUEUE_DEPTH = lrd_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lrd_pkg::lrd_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lrd_pkg::lrd_rsp_type           rsp_data,
   input  logic                           csr_write_en,
   input  logic [lrd_pkg::COLOR_BITS-1:0] csr_write_data
);

   logic [lrd_pkg::COLOR_BITS-1:0] color_ff, color_in;
   lrd_pkg::lrd_cmd_type           front_cmd;
   lrd_pkg::lrd_cmd_type           head_cmd;
   lrd_pkg::lrd_queue_status_type  q_status;
   lrd_pkg::lrd_back_status_type   back_status;

   // Color register
   assign color_in = csr_write_en ? csr_write_data : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else begin
         color_ff <= color_in;
      end
   end

   assign req_ready = !q_status.full;

   lrd_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   lrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_data (front_cmd),
      .pop       (back_status.pop),
      .head      (head_cmd),
      .status    (q_status)
   );

   lrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .color     (color_ff),
      .head      (head_cmd),
      .q_empty   (q_status.empty),
      .status    (back_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Corner pixel waits only behind its own main pixel
   `LRD_IMPLY(a_pend_has_main, back_status.corner_pend, rsp_valid, "corner pending with empty output")
   `LRD_IMPLY(a_pend_not_done, back_status.corner_pend, !rsp_data.line_done, "main pixel flagged last before its corner")
   `LRD_IMPLY(a_pend_no_pop, back_status.corner_pend, !back_status.pop, "item taken while corner pending")
   `LRD_IMPLY_NEXT(a_pend_drains, back_status.corner_pend && rsp_ready, !back_status.corner_pend, "corner pixel not moved to output")

endmodule

/* tb/sv/line_rasterizer_dda_tb.sv */
// Self-checking testbench for the DDA line pixel generator.
`timescale 1ns / 1ps

module line_rasterizer_dda_tb;
   import lrd_pkg::*;

   localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
   localparam int SETTLE      = 8;
   localparam int RANDOM_GOAL = 1050;
   localparam int PHASE_LEN   = 175;
   localparam logic [COLOR_BITS-1:0] DIR_COLOR = 32'hFFFF_FFFF;

   typedef struct {
      lrd_req_type item;
      int          typed_n;    // -1: take the predictor's pixels
      lrd_rsp_type typed_px;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   lrd_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   lrd_rsp_type           rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [COLOR_BITS-1:0] csr_write_data = '0;

   // line state of the predictor
   logic [COLOR_BITS-1:0] color_now = '0;
   bit                    line_active = 0;
   int                    step_idx = 0;
   int                    step_cnt = 0;
   bit                    major_x = 0;
   int                    major_at = 0;
   bit                    major_neg = 0;
   int                    minor_at = 0;
   int                    minor_prev = 0;
   int                    rem = 0;
   int                    delta = 0;
   bit                    corner_fill = 0;

   lrd_rsp_type           pending_pixels[$];
   bit                    steady = 0;
   int                    useful_items = 0;
   int                    lines_started = 0;
   int                    pixels_checked = 0;
   int                    colors_used = 0;
   int                    mismatches = 0;

   line_rasterizer_dda dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic lrd_req_type make_req(input lrd_op_type op, input int sx, input int sy,
                                            input int ex, input int ey, input bit fill);
      lrd_req_type r;
      r.operation    = op;
      r.start_x      = COORD_BITS'(sx);
      r.start_y      = COORD_BITS'(sy);
      r.end_x        = COORD_BITS'(ex);
      r.end_y        = COORD_BITS'(ey);
      r.fill_corners = fill;
      return r;
   endfunction

   function automatic stim_row_type plan_row(input lrd_op_type op, input int sx, input int sy,
                                             input int ex, input int ey, input bit fill,
                                             input int typed_n = -1, input int tx = 0,
                                             input int ty = 0);
      stim_row_type row;
      row.item                 = make_req(op, sx, sy, ex, ey, fill);
      row.typed_n              = typed_n;
      row.typed_px.pixel_x     = COORD_BITS'(tx);
      row.typed_px.pixel_y     = COORD_BITS'(ty);
      row.typed_px.pixel_color = DIR_COLOR;
      row.typed_px.line_done   = 1'b1;
      return row;
   endfunction

   // Map major/minor back to x/y and attach the current color
   function automatic lrd_rsp_type pixel_at(input int maj, input int mnr);
      lrd_rsp_type p;
      p.pixel_x     = COORD_BITS'(major_x ? maj : mnr);
      p.pixel_y     = COORD_BITS'(major_x ? mnr : maj);
      p.pixel_color = color_now;
      p.line_done   = 1'b0;
      return p;
   endfunction

   // Apply one item to the line state; return the number of pixels it yields
   function automatic int rasterize_step(input lrd_req_type item, output lrd_rsp_type first,
                                         output lrd_rsp_type second);
      int sx, sy, ex, ey, dx, dy, count;
      first  = '0;
      second = '0;
      if (item.operation == OP_START) begin
         sx          = item.start_x;
         sy          = item.start_y;
         ex          = item.end_x;
         ey          = item.end_y;
         dx          = ex - sx;
         dy          = ey - sy;
         // ties go to y
         major_x     = iabs(dx) > iabs(dy);
         step_cnt    = major_x ? iabs(dx) : iabs(dy);
         major_at    = major_x ? sx : sy;
         major_neg   = major_x ? (dx < 0) : (dy < 0);
         minor_at    = major_x ? sy : sx;
         minor_prev  = minor_at;
         delta       = major_x ? dy : dx;
         rem         = step_cnt;
         step_idx    = 0;
         corner_fill = item.fill_corners;
         line_active = 1;
         return 0;
      end
      if (!line_active) return 0;
      first = pixel_at(major_at, minor_at);
      count = 1;
      // with corner fill on, a corner pixel follows the main one wherever the minor coordinate moved
      if (corner_fill && minor_at != minor_prev) begin
         second = pixel_at(major_at, minor_prev);
         count  = 2;
      end
      if (step_idx >= step_cnt) begin
         if (count == 2) second.line_done = 1'b1;
         else first.line_done = 1'b1;
         line_active = 0;
         return count;
      end
      // advance the exact quotient and remainder
      minor_prev = minor_at;
      step_idx++;
      major_at  += major_neg ? -1 : 1;
      rem       += 2 * delta;
      if (rem >= 2 * step_cnt) begin
         rem -= 2 * step_cnt;
         minor_at++;
      end else if (rem < 0) begin
         rem += 2 * step_cnt;
         minor_at--;
      end
      return count;
   endfunction

   // Drive one item, hold it until accepted, then queue its pixels
   task automatic send_item(input lrd_req_type item, input int typed_n,
                            input lrd_rsp_type typed_px);
      lrd_rsp_type p0, p1;
      int          got;
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (item.operation == OP_START) lines_started++;
      if (item.operation == OP_START || line_active) useful_items++;
      got = rasterize_step(item, p0, p1);
      if (typed_n >= 0) begin
         got = typed_n;
         p0  = typed_px;
      end
      if (got > 0) pending_pixels.push_back(p0);
      if (got > 1) pending_pixels.push_back(p1);
   endtask

   // Drop valid, let every expected pixel arrive, then let the queue drain
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_draw_color(input logic [COLOR_BITS-1:0] c);
      csr_write_data <= c;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      color_now = c;
      colors_used++;
   endtask

   function automatic int rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return COORD_MIN + int'($urandom_range(0, 20));
      if (r < 30) return COORD_MAX - int'($urandom_range(0, 20));
      return int'($urandom_range(0, 65535)) + COORD_MIN;
   endfunction

   function automatic lrd_req_type noise_advance();
      return make_req(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      1'($urandom_range(0, 1)));
   endfunction

   // Check each accepted pixel against the oldest expectation
   always @(posedge clock) begin : pixel_check
      lrd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d", rsp_data.pixel_x, rsp_data.pixel_y);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
               mismatches++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
               mismatches++;
            end
            if (rsp_data.pixel_color !== want.pixel_color) begin
               $error("pixel_color: expected %h, got %h", want.pixel_color,
                      rsp_data.pixel_color);
               mismatches++;
            end
            if (rsp_data.line_done !== want.line_done) begin
               $error("line_done: expected %0b, got %0b", want.line_done, rsp_data.line_done);
               mismatches++;
            end
         end
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= 29);
   end

   initial begin : stimulus
      stim_row_type plan[$];
      lrd_rsp_type  none;
      int           rand_start, next_break, phase, kind, sx, sy, ex, ey, dx, dy, span, steps;

      none = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_draw_color(DIR_COLOR);

      // directed rows: idle advance, single-point line, extremes, abandon, ties, corners
      plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(OP_START, 5, -7, 5, -7, 0, 0));
      plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0, 1, 5, -7));
      plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 1, 0));
      plan.push_back(plan_row(OP_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1));
      repeat (3) plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(OP_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0));
      repeat (2) plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(OP_START, 0, 0, 3, -3, 1));
      repeat (4) plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(OP_START, -2, 1, 2, 3, 1));
      repeat (5) plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0));
      plan.push_back(plan_row(OP_START, 7, 7, 8, 8, 1));
      repeat (2) plan.push_back(plan_row(OP_ADVANCE, 0, 0, 0, 0, 0));
      foreach (plan[i]) send_item(plan[i].item, plan[i].typed_n, plan[i].typed_px);
      wait_quiet();
      write_draw_color('0);

      // random lines, split into phases with a color change between them
      rand_start = useful_items;
      next_break = PHASE_LEN;
      phase      = 0;
      while (useful_items - rand_start < RANDOM_GOAL) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            sx   = rand_coord();
            sy   = rand_coord();
            span = ($urandom_range(0, 9) == 0) ? 60 : 12;
            dx   = int'($urandom_range(0, 2 * span)) - span;
            dy   = int'($urandom_range(0, 2 * span)) - span;
            // force the occasional diagonal tie or single point
            if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
            if ($urandom_range(0, 19) == 0) begin
               dx = 0;
               dy = 0;
            end
            ex    = clamp_coord(sx + dx);
            ey    = clamp_coord(sy + dy);
            steps = ((iabs(ex - sx) > iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy)) + 1;
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps - 1);
            else if ($urandom_range(0, 6) == 0) steps += $urandom_range(1, 2);
            send_item(make_req(OP_START, sx, sy, ex, ey, 1'($urandom_range(0, 1))), -1, none);
         end else if (kind < 85) begin
            // long line, abandoned after a few pixels
            send_item(make_req(OP_START, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               1'($urandom_range(0, 1))), -1, none);
            steps = $urandom_range(1, 6);
         end else begin
            steps = $urandom_range(1, 3);
         end
         repeat (steps) begin
            send_item(noise_advance(), -1, none);
            steady = (useful_items - rand_start >= 400) && (useful_items - rand_start < 600);
            if (useful_items - rand_start >= next_break) begin
               wait_quiet();
               phase++;
               case (phase % 3)
                  0: write_draw_color('0);
                  1: write_draw_color($urandom);
                  default: write_draw_color(DIR_COLOR);
               endcase
               next_break += PHASE_LEN;
            end
         end
      end
      wait_quiet();

      $display("Sent %0d working items over %0d lines; checked %0d pixels under %0d colors",
               useful_items, lines_started, pixels_checked, colors_used);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
